// File: sv/sbt_pkg.sv
// Shared types, token codes and keyword tables for the source byte tokenizer.
`timescale 1ns / 1ps
package sbt_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int KW_COUNT          = 13;
  localparam int FIFO_DEPTH        = 4;

  localparam logic [3:0] TK_EOF     = 4'd0;
  localparam logic [3:0] TK_IDENT   = 4'd1;
  localparam logic [3:0] TK_KEYWORD = 4'd2;
  localparam logic [3:0] TK_INT     = 4'd3;
  localparam logic [3:0] TK_FLOAT   = 4'd4;
  localparam logic [3:0] TK_STRING  = 4'd5;
  localparam logic [3:0] TK_PAT_ST  = 4'd6;
  localparam logic [3:0] TK_PAT_DYN = 4'd7;
  localparam logic [3:0] TK_OPER    = 4'd8;
  localparam logic [3:0] TK_DELIM   = 4'd9;
  localparam logic [3:0] TK_UNKNOWN = 4'd10;

  // keyword text, right-justified: last character in the low byte
  localparam logic [63:0] KW_STR [KW_COUNT] = '{
    64'("let"), 64'("fn"), 64'("if"), 64'("else"), 64'("while"), 64'("for"),
    64'("return"), 64'("break"), 64'("continue"), 64'("def"), 64'("print"),
    64'("true"), 64'("false")
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd5, 4'd8, 4'd3, 4'd5, 4'd4, 4'd5
  };

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] offset;
    logic [15:0] length;
    logic        last;
  } res_t;

  typedef struct packed {
    logic va;
    logic vb;
    res_t a;
    res_t b;
  } lex_out_t;

  // keep keywords whose character at pos matches c
  function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] mask,
                                                    input logic pos_ok,
                                                    input logic [2:0] pos,
                                                    input logic [7:0] c);
    logic [KW_COUNT-1:0] r;
    logic [3:0]          sh;
    r = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      sh = KW_LEN[i] - 4'd1 - {1'b0, pos};
      if (mask[i] && pos_ok && ({1'b0, pos} < KW_LEN[i]) &&
          (KW_STR[i][{sh[2:0], 3'b000} +: 8] == c)) begin
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// File: sv/sbt_lexer.sv
// Lexer state and per-byte token decision logic.
`timescale 1ns / 1ps
module sbt_lexer #(
  parameter int PB = sbt_pkg::POSITION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic             cmd,
  input  logic [7:0]       c,
  output sbt_pkg::lex_out_t lo
);
  import sbt_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE       = 4'd0,
    M_IDENT      = 4'd1,
    M_IDENT_R    = 4'd2,
    M_NUMBER     = 4'd3,
    M_STRING     = 4'd4,
    M_STRING_ESC = 4'd5,
    M_PAT_OPEN   = 4'd6,
    M_PAT_BODY   = 4'd7,
    M_PAT_CLOSE  = 4'd8
  } mode_t;

  mode_t               mode_r, mode_nxt;
  logic                quote_r, quote_nxt;
  logic                float_r, float_nxt;
  logic [KW_COUNT-1:0] mask_r, mask_nxt;
  logic [PB-1:0]       off_r, off_nxt, line_r, line_nxt, col_r, col_nxt;
  logic [PB-1:0]       soff_r, soff_nxt, sline_r, sline_nxt, scol_r, scol_nxt;

  logic [PB-1:0]       off_inc, line_inc, col_inc, len;
  logic [PB+15:0]      len_w;
  logic [15:0]         len16;
  logic                pos_ok, is_kw;
  logic [KW_COUNT-1:0] len_match;
  logic [7:0]          delim;
  logic [3:0]          pat_kind;

  logic                is_space, is_alpha, is_digit, is_idch;

  logic                pend_v, idle_v, do_idle;
  logic [3:0]          pend_kind, idle_kind;
  res_t                pend_res, idle_res, eof_res;

  assign off_inc  = &off_r  ? off_r  : off_r  + 1'b1;
  assign line_inc = &line_r ? line_r : line_r + 1'b1;
  assign col_inc  = &col_r  ? col_r  : col_r  + 1'b1;

  assign len    = off_r - soff_r;
  assign len_w  = (PB+16)'(len);
  assign len16  = (|len_w[PB+15:16]) ? 16'hFFFF : len_w[15:0];
  assign pos_ok = (len_w[PB+15:3] == '0);

  always_comb begin
    for (int i = 0; i < KW_COUNT; i++) begin
      len_match[i] = (len_w[PB+15:4] == '0) && (len_w[3:0] == KW_LEN[i]);
    end
  end
  assign is_kw = |(mask_r & len_match);

  assign delim    = quote_r ? 8'h27 : 8'h22;
  assign pat_kind = quote_r ? TK_PAT_DYN : TK_PAT_ST;

  assign is_space = (c == 8'h20) || (c inside {[8'd9:8'd13]});
  assign is_alpha = (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
  assign is_digit = c inside {["0":"9"]};
  assign is_idch  = is_alpha || is_digit || (c == "_");

  always_comb begin
    if (c inside {8'h00, "+", "-", "*", "/", "%", "=", "<", ">", "!", "&", "|", "^", "~"}) begin
      idle_kind = TK_OPER;
    end else if (c inside {"(", ")", "{", "}", "[", "]", ";", ",", "."}) begin
      idle_kind = TK_DELIM;
    end else begin
      idle_kind = TK_UNKNOWN;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    float_nxt = float_r;
    mask_nxt  = mask_r;
    off_nxt   = off_inc;
    line_nxt  = line_r;
    col_nxt   = col_inc;
    soff_nxt  = soff_r;
    sline_nxt = sline_r;
    scol_nxt  = scol_r;
    pend_v    = 1'b0;
    pend_kind = TK_IDENT;
    idle_v    = 1'b0;
    do_idle   = 1'b0;

    if (cmd) begin
      case (mode_r)
        M_IDENT, M_IDENT_R: begin
          pend_v    = 1'b1;
          pend_kind = is_kw ? TK_KEYWORD : TK_IDENT;
        end
        M_NUMBER: begin
          pend_v    = 1'b1;
          pend_kind = float_r ? TK_FLOAT : TK_INT;
        end
        M_STRING, M_STRING_ESC: begin
          pend_v    = 1'b1;
          pend_kind = TK_STRING;
        end
        M_PAT_OPEN, M_PAT_BODY: begin
          pend_v    = 1'b1;
          pend_kind = pat_kind;
        end
        default: begin
          pend_v = 1'b0;
        end
      endcase
      mode_nxt  = M_IDLE;
      quote_nxt = 1'b0;
      float_nxt = 1'b0;
      mask_nxt  = '0;
      off_nxt   = '0;
      line_nxt  = PB'(1);
      col_nxt   = PB'(1);
      soff_nxt  = '0;
      sline_nxt = PB'(1);
      scol_nxt  = PB'(1);
    end else begin
      case (mode_r)
        M_IDENT, M_IDENT_R: begin
          if (mode_r == M_IDENT_R && (c == 8'h22 || c == 8'h27)) begin
            quote_nxt = (c == 8'h27);
            mode_nxt  = M_PAT_OPEN;
            soff_nxt  = off_inc;
          end else if (is_idch) begin
            mode_nxt = M_IDENT;
            mask_nxt = kw_filter(mask_r, pos_ok, len_w[2:0], c);
          end else begin
            pend_v    = 1'b1;
            pend_kind = is_kw ? TK_KEYWORD : TK_IDENT;
            do_idle   = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit || c == ".") begin
            if (c == ".") float_nxt = 1'b1;
          end else begin
            pend_v    = 1'b1;
            pend_kind = float_r ? TK_FLOAT : TK_INT;
            do_idle   = 1'b1;
          end
        end
        M_STRING: begin
          if (c == 8'h22) begin
            pend_v    = 1'b1;
            pend_kind = TK_STRING;
            mode_nxt  = M_IDLE;
          end else if (c == 8'h5C) begin
            mode_nxt = M_STRING_ESC;
          end
        end
        M_STRING_ESC: begin
          mode_nxt = M_STRING;
        end
        M_PAT_OPEN: begin
          mode_nxt = M_PAT_BODY;
          if (c == delim) soff_nxt = off_inc;
        end
        M_PAT_BODY: begin
          if (c == delim) begin
            pend_v    = 1'b1;
            pend_kind = pat_kind;
            mode_nxt  = M_PAT_CLOSE;
          end
        end
        M_PAT_CLOSE: begin
          if (c == delim) mode_nxt = M_IDLE;
          else do_idle = 1'b1;
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      if (do_idle) begin
        mode_nxt = M_IDLE;
        if (!is_space) begin
          soff_nxt  = off_r;
          sline_nxt = line_r;
          scol_nxt  = col_r;
          if (is_alpha || c == "_") begin
            mode_nxt = (c == "R") ? M_IDENT_R : M_IDENT;
            mask_nxt = kw_filter('1, 1'b1, 3'd0, c);
          end else if (is_digit) begin
            mode_nxt  = M_NUMBER;
            float_nxt = 1'b0;
          end else if (c == 8'h22) begin
            mode_nxt = M_STRING;
            soff_nxt = off_inc;
          end else begin
            idle_v = 1'b1;
          end
        end
      end

      if (c == 8'h0A) begin
        line_nxt = line_inc;
        col_nxt  = PB'(1);
      end
    end
  end

  always_comb begin
    pend_res = '{kind: pend_kind, line: 16'(sline_r), column: 16'(scol_r),
                 offset: 16'(soff_r), length: len16, last: 1'b0};
    idle_res = '{kind: idle_kind, line: 16'(line_r), column: 16'(col_r),
                 offset: 16'(off_r), length: 16'd1, last: 1'b0};
    eof_res  = '{kind: TK_EOF, line: 16'(line_r), column: 16'(col_r),
                 offset: 16'(off_r), length: 16'd0, last: 1'b0};
  end

  always_comb begin
    lo = '0;
    if (acc) begin
      if (cmd) begin
        if (pend_v) begin
          lo.va     = 1'b1;
          lo.a      = pend_res;
          lo.vb     = 1'b1;
          lo.b      = eof_res;
          lo.b.last = 1'b1;
        end else begin
          lo.va     = 1'b1;
          lo.a      = eof_res;
          lo.a.last = 1'b1;
        end
      end else if (pend_v && idle_v) begin
        lo.va     = 1'b1;
        lo.a      = pend_res;
        lo.vb     = 1'b1;
        lo.b      = idle_res;
        lo.b.last = 1'b1;
      end else if (pend_v || idle_v) begin
        lo.va     = 1'b1;
        lo.a      = pend_v ? pend_res : idle_res;
        lo.a.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      quote_r <= 1'b0;
      float_r <= 1'b0;
      mask_r  <= '0;
      off_r   <= '0;
      line_r  <= PB'(1);
      col_r   <= PB'(1);
      soff_r  <= '0;
      sline_r <= PB'(1);
      scol_r  <= PB'(1);
    end else if (acc) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      float_r <= float_nxt;
      mask_r  <= mask_nxt;
      off_r   <= off_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      soff_r  <= soff_nxt;
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
    end
  end

  a_b_needs_a: assert property (@(posedge clk) disable iff (!rst_n)
    lo.vb |-> lo.va)
    else $error("second result without first");

  a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |-> !lo.va)
    else $error("result without accepted beat");

  a_end_gives_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && cmd) |-> ((lo.vb && lo.b.kind == TK_EOF && lo.b.last) ||
                      (!lo.vb && lo.va && lo.a.kind == TK_EOF && lo.a.last)))
    else $error("end command did not close with eof");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && cmd) |=> (mode_r == M_IDLE && off_r == '0 && line_r == PB'(1)))
    else $error("state not restarted after end");

endmodule

// File: sv/sbt_res_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per beat.
`timescale 1ns / 1ps
module sbt_res_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  sbt_pkg::lex_out_t lo,
  input  logic              pop,
  output logic              room2,
  output logic              not_empty,
  output sbt_pkg::res_t     head
);
  import sbt_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  res_t          mem_r [FIFO_DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt, wp_b;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    n_wr;

  assign n_wr      = {1'b0, lo.va} + {1'b0, lo.vb};
  assign wp_b      = wp_r + 1'b1;
  assign wp_nxt    = wp_r + AW'(n_wr);
  assign rp_nxt    = pop ? rp_r + 1'b1 : rp_r;
  assign cnt_nxt   = cnt_r + CW'(n_wr) - CW'(pop);
  assign room2     = (cnt_r <= CW'(FIFO_DEPTH - 2));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lo.va) mem_r[wp_r] <= lo.a;
    if (lo.vb) mem_r[wp_b] <= lo.b;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty result queue");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    lo.va |-> room2)
    else $error("push without room");

endmodule

// File: sv/source_byte_tokenizer_top.sv
// Top level of the source byte tokenizer.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------------------
//  in_      | in  | in_tvalid/in_tready   | tdata: source_byte; tuser: command
//  out_     | out | out_tvalid/out_tready | tdata: kind,line,column,offset,length; tlast
//
//  One source beat is taken per cycle while in_tready is high; the byte is decided in the cycle it is taken.
//  Each beat yields zero, one or two results into a four-entry result queue.
//  in_tready is low while fewer than two queue entries are free.
//  Output runs at one result per cycle while out_tready is high; two results of a beat leave one after the other.
//  Synchronous active-low reset: line and column 1, offset 0, queue empty.
`timescale 1ns / 1ps
module source_byte_tokenizer_top #(
  parameter int POSITION_BITS = sbt_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [3:0] kind, [19:4] line, [35:20] column,
                                  // [51:36] offset, [67:52] length, [71:68] zero
  output logic        out_tlast   // last result of the input beat
);
  import sbt_pkg::*;

  logic     in_acc, pop, room2;
  lex_out_t lo;
  res_t     head;

  assign in_tready = room2;
  assign in_acc    = in_tvalid && in_tready;
  assign pop       = out_tvalid && out_tready;

  sbt_lexer #(
    .PB(POSITION_BITS)
  ) u_lexer (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (in_acc),
    .cmd  (in_tuser),
    .c    (in_tdata),
    .lo   (lo)
  );

  sbt_res_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .lo       (lo),
    .pop      (pop),
    .room2    (room2),
    .not_empty(out_tvalid),
    .head     (head)
  );

  assign out_tdata = {4'b0000, head.length, head.offset, head.column, head.line, head.kind};
  assign out_tlast = head.last;

endmodule
